### rtl/hse_pkg.sv
// Shared types, constants and SHA-256 helper functions for the HMAC engine.
package hse_pkg;

  localparam logic [63:0] IPAD_WORD = 64'h3636363636363636;
  localparam logic [63:0] OPAD_WORD = 64'h5c5c5c5c5c5c5c5c;
  localparam int KEY_WORDS = 8;

  // Queue entry passed from the front to the back.
  typedef struct packed {
    logic [7:0] message_byte;
    logic       is_last;
    logic       empty_message;
  } hse_item_t;

  typedef logic [31:0] word_t;
  typedef logic [255:0] digest_t;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    begin
      case (t)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/hse_front.sv
// Input stage: registers each accepted item into a small queue for the back end.
module hse_front #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hse_pkg::hse_item_t in_item,
  output logic              q_valid,
  input  logic              q_pop,
  output hse_pkg::hse_item_t q_item
);
  import hse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hse_item_t      slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;

  assign in_stall = (count == (AW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end
endmodule

### rtl/hse_compress.sv
// Iterative SHA-256 compression unit: one round per cycle over a 16-word schedule window.
module hse_compress (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] h_in,
  input  logic [511:0] blk,
  output logic         busy,
  output logic         done,
  output logic [255:0] h_out
);
  import hse_pkg::*;

  logic [511:0] w;
  logic [255:0] v;
  logic [255:0] h0;
  logic [5:0]   rnd;
  logic         running;
  logic [31:0]  a, b, c, d, e, f, g, hh;
  logic [31:0]  t1, t2, s0, s1, w_new;
  logic [31:0]  w0, w1, w9, w14;

  assign {a, b, c, d, e, f, g, hh} = v;
  assign w0  = w[511:480];
  assign w1  = w[479:448];
  assign w9  = w[223:192];
  assign w14 = w[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;
  assign t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + round_k(rnd) + w0;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

  assign busy = running;
  assign h_out = {h0[255:224] + v[255:224], h0[223:192] + v[223:192],
                  h0[191:160] + v[191:160], h0[159:128] + v[159:128],
                  h0[127:96] + v[127:96],   h0[95:64] + v[95:64],
                  h0[63:32] + v[63:32],     h0[31:0] + v[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      rnd     <= '0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        rnd     <= '0;
      end else if (running) begin
        rnd <= rnd + 1'b1;
        if (rnd == 6'd63) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !running) begin
      w  <= blk;
      v  <= h_in;
      h0 <= h_in;
    end else if (running) begin
      w <= {w[479:0], w_new};
      v <= {t1 + t2, a, b, c, d + t1, e, f, g};
    end
  end
endmodule

### rtl/hse_back.sv
// Sequencer: key pads, byte absorption, padding and the outer hash around the compression unit.
module hse_back #(
  parameter int MAX_MESSAGE_BYTES = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [63:0]        cfg_data,
  input  logic               q_valid,
  output logic               q_pop,
  input  hse_pkg::hse_item_t q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [255:0]       digest
);
  import hse_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_IPAD   = 4'd1;
  localparam logic [3:0] ST_OPAD   = 4'd2;
  localparam logic [3:0] ST_ABSORB = 4'd3;
  localparam logic [3:0] ST_FIN1   = 4'd4;
  localparam logic [3:0] ST_FIN2   = 4'd5;
  localparam logic [3:0] ST_OUTER  = 4'd6;
  localparam logic [3:0] ST_OUT    = 4'd7;
  localparam logic [3:0] ST_WAIT   = 4'd8;

  logic [3:0]   state;
  logic [3:0]   ret_state;
  logic [511:0] key;
  logic [255:0] inner_start_state;
  logic [255:0] outer_start_state;
  logic [255:0] running_hash;
  logic [511:0] block_buffer;
  logic [15:0]  message_length;
  logic         keys_stale;
  logic [63:0]  total_bits;

  logic         c_start;
  logic [255:0] c_hin;
  logic [511:0] c_blk;
  logic         c_busy;
  logic         c_done;
  logic [255:0] c_hout;

  logic [5:0]   fill;
  logic [511:0] pad_blk;
  logic [511:0] len_blk;
  logic [15:0]  len_inc;

  hse_compress u_comp (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .h_in  (c_hin),
    .blk   (c_blk),
    .busy  (c_busy),
    .done  (c_done),
    .h_out (c_hout)
  );

  assign fill       = message_length[5:0];
  assign total_bits = {45'd0, message_length, 3'd0} + 64'd512;
  assign len_inc    = message_length + 16'd1;

  // Buffer with 0x80 at the fill point and zeros after it.
  always_comb begin
    pad_blk = block_buffer;
    for (int i = 0; i < 64; i++) begin
      if (i == int'(fill)) begin
        pad_blk[511 - 8*i -: 8] = 8'h80;
      end else if (i > int'(fill)) begin
        pad_blk[511 - 8*i -: 8] = 8'h00;
      end
    end
    len_blk = (fill >= 6'd56) ? 512'd0 : pad_blk;
    len_blk[63:0] = total_bits;
  end

  always_comb begin
    c_start = 1'b0;
    c_hin   = SHA_IV;
    c_blk   = key ^ {KEY_WORDS{IPAD_WORD}};
    q_pop   = 1'b0;
    case (state)
      ST_IPAD: begin
        c_start = !c_busy && !c_done;
      end
      ST_OPAD: begin
        c_start = !c_busy && !c_done;
        c_blk   = key ^ {KEY_WORDS{OPAD_WORD}};
      end
      ST_FIN1: begin
        // The padding block is compressed on its own only when the length does not fit.
        c_start = !c_busy && !c_done && (fill >= 6'd56);
        c_hin   = running_hash;
        c_blk   = pad_blk;
      end
      ST_FIN2: begin
        c_start = !c_busy && !c_done;
        c_hin   = running_hash;
        c_blk   = len_blk;
      end
      ST_OUTER: begin
        c_start = !c_busy && !c_done;
        c_hin   = outer_start_state;
        c_blk   = {running_hash, 8'h80, 184'd0, 64'd768};
      end
      ST_WAIT: begin
        c_start = !c_busy && !c_done;
        c_hin   = running_hash;
        c_blk   = block_buffer;
      end
      ST_ABSORB: begin
        q_pop = q_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      key[511 - 64*cfg_idx -: 64] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ret_state      <= ST_IDLE;
      message_length <= '0;
      keys_stale     <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        keys_stale <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (message_length == 16'd0 && keys_stale && !cfg_we) begin
              state <= ST_IPAD;
            end else if (message_length == 16'd0) begin
              running_hash <= inner_start_state;
              state        <= ST_ABSORB;
            end else begin
              state <= ST_ABSORB;
            end
          end
        end
        ST_IPAD: begin
          if (c_done) begin
            inner_start_state <= c_hout;
            state             <= ST_OPAD;
          end
        end
        ST_OPAD: begin
          if (c_done) begin
            outer_start_state <= c_hout;
            running_hash      <= inner_start_state;
            keys_stale        <= 1'b0;
            state             <= ST_ABSORB;
          end
        end
        ST_ABSORB: begin
          if (q_valid) begin
            ret_state <= (q_item.is_last || q_item.empty_message) ? ST_FIN1 : ST_IDLE;
            state     <= (q_item.is_last || q_item.empty_message) ? ST_FIN1 : ST_IDLE;
            if (!q_item.empty_message && message_length < 16'(MAX_MESSAGE_BYTES)) begin
              block_buffer[511 - 8*fill -: 8] <= q_item.message_byte;
              message_length <= len_inc;
              if (len_inc[5:0] == 6'd0) begin
                state <= ST_WAIT;
              end
            end
          end
        end
        ST_WAIT: begin
          if (c_done) begin
            running_hash <= c_hout;
            state        <= ret_state;
          end
        end
        ST_FIN1: begin
          if (c_done) begin
            running_hash <= c_hout;
            state        <= ST_FIN2;
          end else if (fill < 6'd56 && !c_busy) begin
            state <= ST_FIN2;
          end
        end
        ST_FIN2: begin
          if (c_done) begin
            running_hash <= c_hout;
            state        <= ST_OUTER;
          end
        end
        ST_OUTER: begin
          if (c_done) begin
            digest         <= c_hout;
            out_valid      <= 1'b1;
            message_length <= '0;
            state          <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

### rtl/hmac_sha256_engine_core.sv
// HMAC-SHA256 engine top level: key registers, input queue and the hashing sequencer.
// The engine hashes a byte-serial message with HMAC-SHA256 under a 64-byte key held in
// eight 64-bit registers (write them only while the engine is idle). Bytes enter a
// two-entry queue; the sequencer takes the bytes one at a time, returning to idle after
// each, and at each 64-byte block boundary runs the single shared compression unit (one
// round per cycle) before it takes the next byte. After a key change the first message
// also computes the inner and outer start states. Finishing a message takes two or three
// further compressions before the digest is presented; the digest is held until taken.
// Bytes past MAX_MESSAGE_BYTES are dropped, though their is_last still ends the message.
module hmac_sha256_engine_core #(
  parameter int MAX_MESSAGE_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  message_byte,
  input  logic        is_last,
  input  logic        empty_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_word_0,
  output logic [63:0] digest_word_1,
  output logic [63:0] digest_word_2,
  output logic [63:0] digest_word_3
);
  import hse_pkg::*;

  hse_item_t    in_item;
  hse_item_t    q_item;
  logic         q_valid;
  logic         q_pop;
  logic [255:0] digest;

  assign in_item = '{message_byte: message_byte, is_last: is_last,
                     empty_message: empty_message};

  // The front only queues items; all hashing work happens in the back.
  hse_front #(.DEPTH(2)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  hse_back #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digest    (digest)
  );

  assign digest_word_0 = digest[255:192];
  assign digest_word_1 = digest[191:128];
  assign digest_word_2 = digest[127:64];
  assign digest_word_3 = digest[63:0];
endmodule

### rtl/hse_checker.sv
// Port-level checker for the HMAC engine, bound to the top level.
module hse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] digest_word_0
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word_0))
    else $error("result dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented right after reset");

  a_reset_open: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");
endmodule

bind hmac_sha256_engine_core hse_checker u_hse_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .digest_word_0 (digest_word_0)
);

### dv/tb_top.sv
// Self-checking testbench for the HMAC-SHA256 engine core.
`timescale 1ns / 1ps

module tb_top;
  import hse_pkg::*;

  localparam int MAX_BYTES = 255;
  // Longest quiet stretch: key setup plus several compressions plus receiver stalls.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  // Register indexes of the key words.
  typedef enum logic [2:0] {
    KEY_W0, KEY_W1, KEY_W2, KEY_W3, KEY_W4, KEY_W5, KEY_W6, KEY_W7
  } key_reg_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = KEY_W0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  message_byte = '0;
  logic        is_last = 1'b0;
  logic        empty_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] digest_word_0, digest_word_1, digest_word_2, digest_word_3;

  hmac_sha256_engine_core #(.MAX_MESSAGE_BYTES(MAX_BYTES)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: key registers, start states and the message in progress.
  logic [63:0] key_regs [8];
  logic [31:0] inner_iv [8];
  logic [31:0] outer_iv [8];
  logic [31:0] msg_hash [8];
  logic [7:0]  msg_block [64];
  int          msg_len;
  bit          iv_stale;

  logic [255:0] digest_fifo [$];
  byte_item_t   byte_fifo [$];
  int errors = 0;
  int digests_seen = 0;
  int bytes_sent = 0;
  int watchdog = 0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of a 64-byte block into the chaining state.
  function automatic void sha_compress(ref logic [31:0] h [8], input logic [7:0] blk [64]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    v = h;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) h[t] += v[t];
  endfunction

  function automatic void key_start(ref logic [31:0] h [8], input logic [63:0] pad);
    logic [7:0] blk [64];
    logic [63:0] kw;
    for (int i = 0; i < 64; i++) begin
      kw = key_regs[i / 8] ^ pad;
      blk[i] = kw[63 - 8 * (i % 8) -: 8];
    end
    for (int i = 0; i < 8; i++) h[i] = SHA_IV[255 - 32 * i -: 32];
    sha_compress(h, blk);
  endfunction

  // Standard SHA-256 padding and final compression(s).
  function automatic void sha_finish(ref logic [31:0] h [8], ref logic [7:0] blk [64],
                                     input int fill, input logic [63:0] total);
    logic [63:0] bits;
    bits = total << 3;
    blk[fill] = 8'h80;
    for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
    if (fill >= 56) begin
      sha_compress(h, blk);
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk[56 + i] = bits[63 - 8 * i -: 8];
    sha_compress(h, blk);
  endfunction

  // Advance the HMAC predictor by one accepted item; queue a digest when it ends a message.
  function automatic void hmac_absorb(byte_item_t it);
    logic [7:0] blk [64];
    logic [31:0] h [8];
    if (msg_len == 0) begin
      if (iv_stale) begin
        key_start(inner_iv, IPAD_WORD);
        key_start(outer_iv, OPAD_WORD);
        iv_stale = 0;
      end
      msg_hash = inner_iv;
    end
    if (!it.empty && msg_len < MAX_BYTES) begin
      msg_block[msg_len % 64] = it.data;
      msg_len++;
      if (msg_len % 64 == 0) sha_compress(msg_hash, msg_block);
    end
    if (!(it.last || it.empty)) return;
    sha_finish(msg_hash, msg_block, msg_len % 64, 64'(64 + msg_len));
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++) begin
      {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]} = msg_hash[i];
    end
    h = outer_iv;
    sha_finish(h, blk, 32, 64'd96);
    digest_fifo.push_back({h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]});
    msg_len = 0;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  int  stall_mode = 0;
  bit  accepted_q = 0;

  // Driver: bursts of back-to-back items with random gaps. A presented item holds until
  // accepted, and valid is lowered only for a gap or when no item is left to send.
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_q) begin
        if (gap_left > 0 || byte_fifo.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          {message_byte, is_last, empty_message} <= byte_fifo.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(0, 6);
          end else burst_left--;
        end
      end
      // Receiver stall pattern: long clean stretches mixed with stall-heavy ones.
      out_stall <= (stall_mode != 0) && ($urandom_range(0, 3) < stall_mode);
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    end
  end

  // Monitor: sample handshakes at the rising edge, predict and check.
  always @(posedge clk) begin
    logic [255:0] want;
    accepted_q = 0;
    if (!rst) begin
      watchdog++;
      if (in_valid && !in_stall) begin
        accepted_q = 1;
        hmac_absorb({message_byte, is_last, empty_message});
        bytes_sent++;
        watchdog = 0;
      end
      if (out_valid && !out_stall) begin
        watchdog = 0;
        digests_seen++;
        if (digest_fifo.size() == 0) begin
          $display("unexpected digest at %0t", $time);
          errors++;
        end else begin
          want = digest_fifo.pop_front();
          if (digest_word_0 !== want[255:192])
            report_mismatch("digest_word_0", digest_word_0, want[255:192]);
          if (digest_word_1 !== want[191:128])
            report_mismatch("digest_word_1", digest_word_1, want[191:128]);
          if (digest_word_2 !== want[127:64])
            report_mismatch("digest_word_2", digest_word_2, want[127:64]);
          if (digest_word_3 !== want[63:0])
            report_mismatch("digest_word_3", digest_word_3, want[63:0]);
        end
      end
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", watchdog);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic push_msg(int len, bit end_empty);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data = $urandom_range(0, 255);
      it.last = (i == len - 1) && !end_empty;
      it.empty = 1'b0;
      byte_fifo.push_back(it);
    end
    if (end_empty || len == 0) begin
      it.data = $urandom_range(0, 255);
      it.last = $urandom_range(0, 1);
      it.empty = 1'b1;
      byte_fifo.push_back(it);
    end
  endtask

  // Wait until all items are taken and all digests are back, then let the engine settle.
  task automatic drain();
    while (byte_fifo.size() != 0 || in_valid || digest_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Key write at the falling edge, taken at the next rising edge; predictor updated there.
  task automatic write_key(key_reg_e idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    key_regs[idx] = val;
    iv_stale = 1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(int style);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case (style)
        0: v = '0;
        1: v = '1;
        2: v = (i < 4) ? {$urandom, $urandom} : 64'h0;
        default: v = {$urandom, $urandom};
      endcase
      write_key(key_reg_e'(i), v);
    end
  endtask

  initial begin
    byte_item_t it;
    int len;
    for (int i = 0; i < 8; i++) key_regs[i] = '0;
    msg_len = 0;
    iv_stale = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset key (all zero), then extremes and the special endings.
    push_msg(0, 1);                      // empty message
    push_msg(1, 0);                      // single byte
    it = '{8'hff, 1'b1, 1'b0}; byte_fifo.push_back(it);
    it = '{8'h00, 1'b1, 1'b0}; byte_fifo.push_back(it);
    push_msg(3, 1);                      // empty flag ends a message mid-way
    it = '{8'haa, 1'b1, 1'b1}; byte_fifo.push_back(it);  // both flags set
    drain();
    load_key(1);
    push_msg(55, 0);                     // padding fits in one block
    push_msg(56, 0);                     // padding spills into another block
    push_msg(64, 0);                     // exact block boundary
    drain();
    load_key(2);
    push_msg(MAX_BYTES + 3, 0);          // overlong: tail bytes dropped
    drain();
    load_key(3);
    push_msg(5, 0);
    push_msg(2, 0);                      // two messages under one key
    drain();

    // Random: mostly short messages, a few long ones, keys changed between phases.
    for (int phase = 0; phase < 4; phase++) begin
      load_key(phase == 3 ? 0 : 3);
      for (int m = 0; m < 5; m++) begin
        len = ($urandom_range(0, 23) == 0) ? $urandom_range(60, 130)
                                          : $urandom_range(0, 12);
        push_msg(len, $urandom_range(0, 7) == 0);
      end
      drain();
    end
    // A key write while a message is in flight would be illegal, so no mid-message
    // key case is driven; keys change only between drained phases.

    $display("run covered %0d items and %0d digests over several keys", bytes_sent,
             digests_seen);
    $display("including empty, overlong and block-boundary messages");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hse_pkg.sv
rtl/hse_front.sv
rtl/hse_compress.sv
rtl/hse_back.sv
rtl/hmac_sha256_engine_core.sv
rtl/hse_checker.sv
dv/tb_top.sv
